### rtl/tpbd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the tracker pattern byte decoder.
// No dependencies; imported by every module of the block.

package tpbd_pkg;

   localparam int NUM_CHANNELS = 3;

   // Byte class boundaries (last code of each class unless noted)
   localparam logic [7:0] CODE_IGNORE     = 8'h00;
   localparam logic [7:0] CODE_NOTE_LAST  = 8'h60;
   localparam logic [7:0] CODE_SMP_BASE   = 8'h60;
   localparam logic [7:0] CODE_SMP_LAST   = 8'h6f;
   localparam logic [7:0] CODE_ORN_BASE   = 8'h6f;
   localparam logic [7:0] CODE_ORN_LAST   = 8'h7f;
   localparam logic [7:0] CODE_SKIP_BASE  = 8'h80;
   localparam logic [7:0] CODE_SKIP_LAST  = 8'hbf;
   localparam logic [7:0] CODE_ENV_PLAIN  = 8'hc0;
   localparam logic [7:0] CODE_ENV_LAST   = 8'hcf;
   localparam logic [7:0] CODE_REL_LAST   = 8'hdf;
   localparam logic [7:0] CODE_EMPTY_LAST = 8'hef;
   localparam logic [7:0] CODE_GLIDE      = 8'hf0;
   localparam logic [7:0] CODE_VOL_BASE   = 8'hf0;

   typedef enum logic [1:0] {
      AWAIT_NONE  = 2'd0,
      AWAIT_ENV   = 2'd1,
      AWAIT_GLIDE = 2'd2
   } await_type;

   typedef enum logic [1:0] {
      LINE_NOTE    = 2'd0,
      LINE_RELEASE = 2'd1,
      LINE_EMPTY   = 2'd2
   } line_kind_type;

   localparam logic [1:0] ENV_KEEP = 2'd0;
   localparam logic [1:0] ENV_ON   = 2'd1;
   localparam logic [1:0] ENV_OFF  = 2'd2;

   // Per-channel line record plus the channel's skip period
   typedef struct packed {
      await_type   await_param;
      logic [3:0]  sample;
      logic [4:0]  ornament;
      logic [3:0]  volume;
      logic [1:0]  env_mode;
      logic [3:0]  env_shape;
      logic [7:0]  env_value;
      logic        glide_valid;
      logic [7:0]  glide;
      logic [5:0]  skip_period;
   } rec_type;

   // One completed line, without its channel
   typedef struct packed {
      line_kind_type line_kind;
      logic [6:0]    note_value;
      logic [3:0]    sample_sel;
      logic [4:0]    ornament_sel;
      logic [3:0]    volume_sel;
      logic [1:0]    env_mode;
      logic [3:0]    env_shape;
      logic [7:0]    env_value;
      logic          glide_valid;
      logic [7:0]    glide;
      logic [5:0]    empty_rows;
   } line_type;

endpackage

### rtl/tpbd_chan_state.sv
`timescale 1ns / 1ps
// Per-channel record registers with one read port and one write port, selected by channel.
// Depends on tpbd_pkg.

module tpbd_chan_state
   import tpbd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic [1:0] chan,
   input  logic       wr_en,
   input  rec_type    wr_rec,
   output logic       chan_ok,
   output rec_type    rd_rec
);

   rec_type                  rec_ff [NUM_CHANNELS];
   rec_type                  rec_in [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0]  hit;

   always_comb begin
      rd_rec = '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         hit[i] = ({2'b00, chan} == 4'(i));
         if (hit[i]) begin
            rd_rec = rec_ff[i];
         end
      end
      chan_ok = |hit;
   end

   always_comb begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         rec_in[i] = (wr_en && hit[i]) ? wr_rec : rec_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         if (reset) begin
            rec_ff[i] <= '0;
         end else begin
            rec_ff[i] <= rec_in[i];
         end
      end
   end

endmodule

### rtl/tpbd_decode.sv
`timescale 1ns / 1ps
// Decodes one pattern byte against its channel's record: next record and completed line.
// Depends on tpbd_pkg.

module tpbd_decode
   import tpbd_pkg::*;
(
   input  rec_type    cur_rec,
   input  logic       new_pattern,
   input  logic [7:0] code_byte,
   output rec_type    next_rec,
   output logic       line_done,
   output line_type   line
);

   rec_type        base_rec;
   line_kind_type  kind;
   logic [6:0]     note;

   always_comb begin
      base_rec  = new_pattern ? rec_type'('0) : cur_rec;
      next_rec  = base_rec;
      line_done = 1'b0;
      kind      = LINE_NOTE;
      note      = '0;

      if (base_rec.await_param == AWAIT_ENV) begin
         next_rec.env_value   = code_byte;
         next_rec.await_param = AWAIT_NONE;
      end else if (base_rec.await_param == AWAIT_GLIDE) begin
         next_rec.glide       = code_byte;
         next_rec.glide_valid = 1'b1;
         next_rec.await_param = AWAIT_NONE;
      end else if (code_byte == CODE_IGNORE) begin
         next_rec = base_rec;
      end else if (code_byte <= CODE_NOTE_LAST) begin
         line_done = 1'b1;
         note      = 7'(code_byte - 8'd1);
      end else if (code_byte <= CODE_SMP_LAST) begin
         next_rec.sample = 4'(code_byte - CODE_SMP_BASE);
      end else if (code_byte <= CODE_ORN_LAST) begin
         next_rec.ornament    = 5'(code_byte - CODE_ORN_BASE);
         next_rec.env_mode    = ENV_OFF;
         next_rec.env_shape   = '0;
         next_rec.env_value   = '0;
         next_rec.glide_valid = 1'b1;
         next_rec.glide       = '0;
      end else if (code_byte <= CODE_SKIP_LAST) begin
         next_rec.skip_period = 6'(code_byte - CODE_SKIP_BASE);
      end else if (code_byte <= CODE_ENV_LAST) begin
         next_rec.env_mode    = ENV_ON;
         next_rec.env_shape   = code_byte[3:0];
         next_rec.env_value   = '0;
         next_rec.ornament    = 5'd1;
         next_rec.glide_valid = 1'b1;
         next_rec.glide       = '0;
         if (code_byte != CODE_ENV_PLAIN) begin
            next_rec.await_param = AWAIT_ENV;
         end
      end else if (code_byte <= CODE_REL_LAST) begin
         line_done = 1'b1;
         kind      = LINE_RELEASE;
      end else if (code_byte <= CODE_EMPTY_LAST) begin
         line_done = 1'b1;
         kind      = LINE_EMPTY;
      end else if (code_byte == CODE_GLIDE) begin
         next_rec.await_param = AWAIT_GLIDE;
      end else begin
         next_rec.volume = 4'(code_byte - CODE_VOL_BASE);
      end

      // A completed line clears the record but keeps the skip period
      if (line_done) begin
         next_rec             = '0;
         next_rec.skip_period = base_rec.skip_period;
      end
   end

   always_comb begin
      line.line_kind    = kind;
      line.note_value   = note;
      line.sample_sel   = base_rec.sample;
      line.ornament_sel = base_rec.ornament;
      line.volume_sel   = base_rec.volume;
      line.env_mode     = base_rec.env_mode;
      line.env_shape    = base_rec.env_shape;
      line.env_value    = base_rec.env_value;
      line.glide_valid  = base_rec.glide_valid;
      line.glide        = base_rec.glide;
      line.empty_rows   = base_rec.skip_period;
   end

endmodule

### rtl/tracker_pattern_byte_decoder.sv
`timescale 1ns / 1ps
// Top level of the tracker pattern byte decoder: input register, decode, result register.
// Depends on tpbd_pkg, tpbd_chan_state and tpbd_decode.
//
// Usage:
//   The req_ channel carries one pattern byte per word, tagged with its channel
//   and a new-pattern flag. The rsp_ channel carries one completed line record
//   per word; a note, release or empty byte produces a line, every other byte
//   only updates the channel's pending record or skip period. Bytes tagged
//   with a channel at or above NUM_CHANNELS are dropped.
//   A word in the input register is decoded once the result register is free;
//   its line, if any, is loaded there and shows on rsp_valid. One word per cycle
//   is taken while the receiver keeps up; a byte for the same channel may follow
//   immediately. Throughput is set by the single decode stage between the input
//   register and the result register, which reads and writes the channel record
//   in the same cycle.
//   Reset clears all channel records and skip periods and empties both
//   registers. When the receiver stalls, the result register holds its line and
//   the input register holds one word; req_ready drops once both are full.

module tracker_pattern_byte_decoder
   import tpbd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_chan,
   input  logic              req_new_pattern,
   input  logic [7:0]        req_code_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_out_chan,
   output logic [1:0]        rsp_line_kind,
   output logic [6:0]        rsp_note_value,
   output logic [3:0]        rsp_sample_sel,
   output logic [4:0]        rsp_ornament_sel,
   output logic [3:0]        rsp_volume_sel,
   output logic [1:0]        rsp_env_mode,
   output logic [3:0]        rsp_env_shape,
   output logic [7:0]        rsp_env_value,
   output logic              rsp_glide_valid,
   output logic signed [7:0] rsp_glide,
   output logic [5:0]        rsp_empty_rows
);

   logic       in_valid_ff, in_valid_in;
   logic [1:0] in_chan_ff;
   logic       in_new_ff;
   logic [7:0] in_byte_ff;

   logic       out_valid_ff, out_valid_in;
   logic [1:0] out_chan_ff;
   line_type   out_line_ff;

   logic       out_free;
   logic       fire;
   logic       chan_ok;
   rec_type    cur_rec;
   rec_type    next_rec;
   logic       line_done;
   line_type   line;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   tpbd_chan_state u_state (
      .clock   (clock),
      .reset   (reset),
      .chan    (in_chan_ff),
      .wr_en   (fire && chan_ok),
      .wr_rec  (next_rec),
      .chan_ok (chan_ok),
      .rd_rec  (cur_rec)
   );

   tpbd_decode u_decode (
      .cur_rec     (cur_rec),
      .new_pattern (in_new_ff),
      .code_byte   (in_byte_ff),
      .next_rec    (next_rec),
      .line_done   (line_done),
      .line        (line)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (fire) begin
         out_valid_in = chan_ok && line_done;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers: load on acceptance, hold otherwise
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_chan_ff <= req_chan;
         in_new_ff  <= req_new_pattern;
         in_byte_ff <= req_code_byte;
      end
      if (fire && chan_ok && line_done) begin
         out_chan_ff <= in_chan_ff;
         out_line_ff <= line;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_out_chan     = out_chan_ff;
   assign rsp_line_kind    = out_line_ff.line_kind;
   assign rsp_note_value   = out_line_ff.note_value;
   assign rsp_sample_sel   = out_line_ff.sample_sel;
   assign rsp_ornament_sel = out_line_ff.ornament_sel;
   assign rsp_volume_sel   = out_line_ff.volume_sel;
   assign rsp_env_mode     = out_line_ff.env_mode;
   assign rsp_env_shape    = out_line_ff.env_shape;
   assign rsp_env_value    = out_line_ff.env_value;
   assign rsp_glide_valid  = out_line_ff.glide_valid;
   assign rsp_glide        = signed'(out_line_ff.glide);
   assign rsp_empty_rows   = out_line_ff.empty_rows;

endmodule

### rtl/tpbd_checker.sv
`timescale 1ns / 1ps
// Port-level checks on the decoder's result channel, bound to the top level.
// Depends on tpbd_pkg and tracker_pattern_byte_decoder.

module tpbd_checker
   import tpbd_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [1:0]        rsp_out_chan,
   input logic [1:0]        rsp_line_kind,
   input logic [6:0]        rsp_note_value,
   input logic [1:0]        rsp_env_mode,
   input logic [3:0]        rsp_env_shape,
   input logic [7:0]        rsp_env_value,
   input logic              rsp_glide_valid,
   input logic signed [7:0] rsp_glide
);

   // Hold a stalled word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_chan) && $stable(rsp_glide))
      else $error("rsp word dropped or changed while stalled");

   a_note_only_on_note: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_line_kind != LINE_NOTE) |-> rsp_note_value == 7'd0)
      else $error("note value on a release or empty line");

   a_env_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_env_mode != ENV_ON) |-> rsp_env_shape == 4'd0 && rsp_env_value == 8'd0)
      else $error("envelope shape or value without envelope on");

   a_glide_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_glide_valid |-> rsp_glide == 8'sd0)
      else $error("glide step without glide valid");

   a_chan_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> {2'b00, rsp_out_chan} < 4'(NUM_CHANNELS))
      else $error("line for a channel out of range");

endmodule

bind tracker_pattern_byte_decoder tpbd_checker u_tpbd_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_out_chan    (rsp_out_chan),
   .rsp_line_kind   (rsp_line_kind),
   .rsp_note_value  (rsp_note_value),
   .rsp_env_mode    (rsp_env_mode),
   .rsp_env_shape   (rsp_env_shape),
   .rsp_env_value   (rsp_env_value),
   .rsp_glide_valid (rsp_glide_valid),
   .rsp_glide       (rsp_glide)
);

### test/tracker_pattern_byte_decoder_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for tracker_pattern_byte_decoder: directed table, then random streams.
// Depends on tpbd_pkg and the decoder RTL; holds its own per-channel line predictor.

module tracker_pattern_byte_decoder_tb;
   import tpbd_pkg::*;

   typedef struct {
      logic [1:0] chan;
      line_type   body;
   } line_word_type;

   typedef struct {
      logic          typed;
      line_word_type want;
   } typed_entry_type;

   typedef struct {
      logic [1:0]    chan;
      logic          new_pattern;
      logic [7:0]    code;
      logic          typed;
      line_kind_type kind;
      logic [6:0]    note;
   } stim_row_type;

   localparam int DIR_ROWS = 25;
   localparam int RANDOM_WORDS = 775;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [1:0]        req_chan;
   logic              req_new_pattern;
   logic [7:0]        req_code_byte;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [1:0]        rsp_out_chan;
   logic [1:0]        rsp_line_kind;
   logic [6:0]        rsp_note_value;
   logic [3:0]        rsp_sample_sel;
   logic [4:0]        rsp_ornament_sel;
   logic [3:0]        rsp_volume_sel;
   logic [1:0]        rsp_env_mode;
   logic [3:0]        rsp_env_shape;
   logic [7:0]        rsp_env_value;
   logic              rsp_glide_valid;
   logic signed [7:0] rsp_glide;
   logic [5:0]        rsp_empty_rows;

   rec_type         chan_rec [NUM_CHANNELS];
   line_word_type   line_q [$];
   typed_entry_type typed_q [$];
   int unsigned     fail_count = 0;
   logic            send_calm = 1'b0;
   logic            recv_calm = 1'b0;

   // Rows with kind/note typed in expect a line with every other field zero.
   stim_row_type dir_rows [DIR_ROWS] = '{
      '{2'd0, 1'b0, 8'h00, 1'b0, LINE_NOTE, 7'd0},
      '{2'd0, 1'b0, 8'h01, 1'b1, LINE_NOTE, 7'd0},
      '{2'd1, 1'b0, 8'h60, 1'b1, LINE_NOTE, 7'd95},
      '{2'd3, 1'b0, 8'h01, 1'b0, LINE_NOTE, 7'd0},
      '{2'd2, 1'b0, 8'hbf, 1'b0, LINE_NOTE, 7'd0},
      '{2'd2, 1'b0, 8'h61, 1'b0, LINE_NOTE, 7'd0},
      '{2'd2, 1'b0, 8'h6f, 1'b0, LINE_NOTE, 7'd0},
      '{2'd2, 1'b0, 8'hf1, 1'b0, LINE_NOTE, 7'd0},
      '{2'd2, 1'b0, 8'hff, 1'b0, LINE_NOTE, 7'd0},
      '{2'd2, 1'b0, 8'h70, 1'b0, LINE_NOTE, 7'd0},
      '{2'd2, 1'b0, 8'hf0, 1'b0, LINE_NOTE, 7'd0},
      '{2'd2, 1'b0, 8'h80, 1'b0, LINE_NOTE, 7'd0},
      '{2'd2, 1'b0, 8'hdf, 1'b0, LINE_NOTE, 7'd0},
      '{2'd1, 1'b0, 8'hc0, 1'b0, LINE_NOTE, 7'd0},
      '{2'd1, 1'b0, 8'he0, 1'b0, LINE_NOTE, 7'd0},
      '{2'd0, 1'b0, 8'hcf, 1'b0, LINE_NOTE, 7'd0},
      '{2'd0, 1'b0, 8'h00, 1'b0, LINE_NOTE, 7'd0},
      '{2'd0, 1'b0, 8'h7f, 1'b0, LINE_NOTE, 7'd0},
      '{2'd0, 1'b0, 8'hc1, 1'b0, LINE_NOTE, 7'd0},
      '{2'd0, 1'b0, 8'hff, 1'b0, LINE_NOTE, 7'd0},
      '{2'd0, 1'b0, 8'hef, 1'b0, LINE_NOTE, 7'd0},
      '{2'd1, 1'b0, 8'hf0, 1'b0, LINE_NOTE, 7'd0},
      '{2'd1, 1'b1, 8'hd0, 1'b1, LINE_RELEASE, 7'd0},
      '{2'd0, 1'b0, 8'hf0, 1'b0, LINE_NOTE, 7'd0},
      '{2'd0, 1'b0, 8'h7f, 1'b0, LINE_NOTE, 7'd0}
   };

   tracker_pattern_byte_decoder DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_chan         (req_chan),
      .req_new_pattern  (req_new_pattern),
      .req_code_byte    (req_code_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_chan     (rsp_out_chan),
      .rsp_line_kind    (rsp_line_kind),
      .rsp_note_value   (rsp_note_value),
      .rsp_sample_sel   (rsp_sample_sel),
      .rsp_ornament_sel (rsp_ornament_sel),
      .rsp_volume_sel   (rsp_volume_sel),
      .rsp_env_mode     (rsp_env_mode),
      .rsp_env_shape    (rsp_env_shape),
      .rsp_env_value    (rsp_env_value),
      .rsp_glide_valid  (rsp_glide_valid),
      .rsp_glide        (rsp_glide),
      .rsp_empty_rows   (rsp_empty_rows)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

   // Decode one byte against the channel records; returns 1 when a line completes.
   function automatic logic decode_line(input logic [1:0] c, input logic np,
                                        input logic [7:0] b, output line_type ln);
      rec_type r;
      ln = '0;
      if (c >= NUM_CHANNELS) return 1'b0;
      r = chan_rec[c];
      if (np) r = '0;
      if (r.await_param == AWAIT_ENV) begin
         r.env_value = b;
         r.await_param = AWAIT_NONE;
         chan_rec[c] = r;
         return 1'b0;
      end
      if (r.await_param == AWAIT_GLIDE) begin
         r.glide = b;
         r.glide_valid = 1'b1;
         r.await_param = AWAIT_NONE;
         chan_rec[c] = r;
         return 1'b0;
      end
      if (b == CODE_IGNORE) begin
         chan_rec[c] = r;
         return 1'b0;
      end
      if (b <= CODE_NOTE_LAST || (b > CODE_ENV_LAST && b <= CODE_EMPTY_LAST)) begin
         if (b <= CODE_NOTE_LAST) begin
            ln.line_kind = LINE_NOTE;
            ln.note_value = 7'(b - 8'd1);
         end else if (b <= CODE_REL_LAST) begin
            ln.line_kind = LINE_RELEASE;
         end else begin
            ln.line_kind = LINE_EMPTY;
         end
         ln.sample_sel = r.sample;
         ln.ornament_sel = r.ornament;
         ln.volume_sel = r.volume;
         ln.env_mode = r.env_mode;
         ln.env_shape = r.env_shape;
         ln.env_value = r.env_value;
         ln.glide_valid = r.glide_valid;
         ln.glide = r.glide;
         ln.empty_rows = r.skip_period;
         // clear the record, keep the skip period
         chan_rec[c] = '0;
         chan_rec[c].skip_period = r.skip_period;
         return 1'b1;
      end
      if (b <= CODE_SMP_LAST) begin
         r.sample = 4'(b - CODE_SMP_BASE);
      end else if (b <= CODE_ORN_LAST) begin
         r.ornament = 5'(b - CODE_ORN_BASE);
         r.env_mode = ENV_OFF;
         r.env_shape = '0;
         r.env_value = '0;
         r.glide_valid = 1'b1;
         r.glide = '0;
      end else if (b <= CODE_SKIP_LAST) begin
         r.skip_period = 6'(b - CODE_SKIP_BASE);
      end else if (b <= CODE_ENV_LAST) begin
         r.env_mode = ENV_ON;
         r.env_shape = b[3:0];
         r.env_value = '0;
         r.ornament = 5'd1;
         r.glide_valid = 1'b1;
         r.glide = '0;
         if (b != CODE_ENV_PLAIN) r.await_param = AWAIT_ENV;
      end else if (b == CODE_GLIDE) begin
         r.await_param = AWAIT_GLIDE;
      end else begin
         r.volume = 4'(b - CODE_VOL_BASE);
      end
      chan_rec[c] = r;
      return 1'b0;
   endfunction

   function automatic logic [7:0] random_code();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 10) return 8'($urandom);
      if (pick < 22) return 8'($urandom_range(8'h01, 8'h60));
      if (pick < 32) return 8'($urandom_range(8'h61, 8'h6f));
      if (pick < 40) return 8'($urandom_range(8'h70, 8'h7f));
      if (pick < 50) return 8'($urandom_range(8'h80, 8'hbf));
      if (pick < 60) return 8'($urandom_range(8'hc0, 8'hcf));
      if (pick < 67) return 8'($urandom_range(8'hd0, 8'hdf));
      if (pick < 75) return 8'($urandom_range(8'he0, 8'hef));
      if (pick < 83) return CODE_GLIDE;
      if (pick < 93) return 8'($urandom_range(8'hf1, 8'hff));
      return CODE_IGNORE;
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_word(input logic [1:0] c, input logic np, input logic [7:0] b,
                            input typed_entry_type te);
      int unsigned gap;
      if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
      gap = send_calm ? 0 : $urandom_range(0, 19);
      typed_q.insert(typed_q.size(), te);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_chan <= c;
      req_new_pattern <= np;
      req_code_byte <= b;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Predict on every accepted byte, check every accepted line.
   always @(posedge clock) begin
      line_type        ln;
      line_word_type   want_w;
      typed_entry_type te;
      if (!reset) begin
         if (req_valid && req_ready) begin
            te = typed_q.pop_front();
            if (decode_line(req_chan, req_new_pattern, req_code_byte, ln)) begin
               if (te.typed) begin
                  line_q.insert(line_q.size(), te.want);
               end else begin
                  want_w.chan = req_chan;
                  want_w.body = ln;
                  line_q.insert(line_q.size(), want_w);
               end
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (line_q.size() == 0) begin
               $error("line word on channel %0d with no line expected", rsp_out_chan);
               fail_count++;
            end else begin
               want_w = line_q.pop_front();
               check_field("out_chan", want_w.chan, rsp_out_chan);
               check_field("line_kind", want_w.body.line_kind, rsp_line_kind);
               check_field("note_value", want_w.body.note_value, rsp_note_value);
               check_field("sample_sel", want_w.body.sample_sel, rsp_sample_sel);
               check_field("ornament_sel", want_w.body.ornament_sel, rsp_ornament_sel);
               check_field("volume_sel", want_w.body.volume_sel, rsp_volume_sel);
               check_field("env_mode", want_w.body.env_mode, rsp_env_mode);
               check_field("env_shape", want_w.body.env_shape, rsp_env_shape);
               check_field("env_value", want_w.body.env_value, rsp_env_value);
               check_field("glide_valid", want_w.body.glide_valid, rsp_glide_valid);
               check_field("glide", $signed(want_w.body.glide), rsp_glide);
               check_field("empty_rows", want_w.body.empty_rows, rsp_empty_rows);
            end
         end
      end
   end

   // Receiver: stall a random number of cycles before each line word.
   initial begin
      int unsigned stall;
      rsp_ready = 1'b0;
      @(negedge reset);
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 29) == 0) recv_calm = !recv_calm;
         stall = recv_calm ? 0 : $urandom_range(0, 19);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   initial begin
      typed_entry_type te;
      int              counted;
      logic [1:0]      c;
      logic            np;
      logic [7:0]      b;
      for (int i = 0; i < NUM_CHANNELS; i++) chan_rec[i] = '0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_chan = '0;
      req_new_pattern = 1'b0;
      req_code_byte = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         te.typed = dir_rows[i].typed;
         te.want.chan = dir_rows[i].chan;
         te.want.body = '0;
         te.want.body.line_kind = dir_rows[i].kind;
         te.want.body.note_value = dir_rows[i].note;
         send_word(dir_rows[i].chan, dir_rows[i].new_pattern, dir_rows[i].code, te);
      end

      te.typed = 1'b0;
      counted = 0;
      c = 2'd0;
      while (counted < RANDOM_WORDS) begin
         // hold off until the decoder has drained
         if (counted == RANDOM_WORDS / 2) begin
            req_valid <= 1'b0;
            do @(negedge clock); while (line_q.size() != 0);
         end
         // stay on one channel for a while so lines build up
         if ($urandom_range(0, 99) < 40) begin
            c = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, NUM_CHANNELS - 1));
         end
         np = ($urandom_range(0, 19) == 0);
         b = random_code();
         counted++;
         send_word(c, np, b, te);
      end
      req_valid <= 1'b0;

      while (line_q.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
